// ===== hw/rtl/dgld_pkg.sv =====
package dgld_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_W      = 11;
  localparam int POS_W      = 10;
  localparam int THR_W      = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_THRESHOLD = 2'd2;

  localparam logic [DIM_W-1:0] LINE_WIDTH_RST   = 11'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam logic [THR_W-1:0] COS_THR_RST      = 16'd13107;

  localparam int DIM_MIN  = 5;
  localparam int DIM_CAP  = 1024;

  // Squared threshold is Q0.30; the squared dot product is scaled to match
  localparam int SQ_SHIFT = 30;
  localparam int T2_W     = 31;

  // Cosine test pipeline: products, sums, six multiply steps, compare
  localparam int COS_LAT  = 9;

endpackage

// ===== hw/rtl/depth_grid_leap_detector.sv =====
// Leap detector for an organized depth grid streamed in raster order, one
// XYZ point per item. Each item judges the pixel two rows up and two columns
// left of it: one result per item once the arriving position is at row 4 and
// column 4 or beyond, none for items nearer the top or left edge. A result
// reports the centre position, whether all ten cross-window points are
// valid (nonzero), and whether both the horizontal and vertical cosines of
// the outer difference vectors fall below the signed Q0.15 threshold. Rate is
// one item per clock while the output skid entry is free: the column store
// has one read and one write port and each item reads and rewrites exactly
// one column entry. Results pass through the nine-stage cosine pipeline
// (wide products are built from partial products over six steps). Storage
// is MAX_WIDTH entries, each holding four points of one column. Assert
// start_of_frame on the first point of a frame; write configuration only
// while no item is in flight.
module depth_grid_leap_detector #(
  parameter int MAX_WIDTH  = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [15:0]                  in_point_x,
  input  logic signed [15:0]                  in_point_y,
  input  logic signed [15:0]                  in_point_z,
  input  logic                                in_start_of_frame,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dgld_pkg::POS_W-1:0]          out_center_row,
  output logic [dgld_pkg::POS_W-1:0]          out_center_col,
  output logic                                out_is_candidate,
  output logic                                out_is_leap,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dgld_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dgld_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int PTW  = 3 * CB;
  localparam int EW   = 4 * PTW;
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int XW   = (CB > 16) ? CB : 16;
  localparam int WCAP = (MAX_WIDTH < dgld_pkg::DIM_CAP) ? MAX_WIDTH : dgld_pkg::DIM_CAP;
  localparam int PW   = dgld_pkg::POS_W;
  localparam int DMW  = dgld_pkg::DIM_W;
  localparam int LAT  = dgld_pkg::COS_LAT;

  typedef struct packed {
    logic ok;
    logic low;
  } vverdict_t;

  typedef struct packed {
    logic          v;
    logic          has;
    logic          vok;
    logic          hok;
    logic [PW-1:0] row;
    logic [PW-1:0] col;
  } meta_t;

  // ---------------------------------------------------------------- config
  logic [DMW-1:0]                        line_width_r, frame_height_r;
  logic signed [dgld_pkg::THR_W-1:0]     cos_thr_r;
  logic [DMW-1:0]                        w_used, h_used;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= dgld_pkg::LINE_WIDTH_RST;
      frame_height_r <= dgld_pkg::FRAME_HEIGHT_RST;
      cos_thr_r      <= dgld_pkg::COS_THR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dgld_pkg::CFG_LINE_WIDTH:    line_width_r   <= cfg_data[DMW-1:0];
        dgld_pkg::CFG_FRAME_HEIGHT:  frame_height_r <= cfg_data[DMW-1:0];
        dgld_pkg::CFG_COS_THRESHOLD: cos_thr_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp geometry to what the store and counters support
  always_comb begin
    priority if (line_width_r < DMW'(dgld_pkg::DIM_MIN)) begin
      w_used = DMW'(dgld_pkg::DIM_MIN);
    end else if (line_width_r > DMW'(WCAP)) begin
      w_used = DMW'(WCAP);
    end else begin
      w_used = line_width_r;
    end
    priority if (frame_height_r < DMW'(dgld_pkg::DIM_MIN)) begin
      h_used = DMW'(dgld_pkg::DIM_MIN);
    end else if (frame_height_r > DMW'(dgld_pkg::DIM_CAP)) begin
      h_used = DMW'(dgld_pkg::DIM_CAP);
    end else begin
      h_used = frame_height_r;
    end
  end

  // ------------------------------------------------------------ stage 0
  // The whole pipeline advances together; it stalls only when the output
  // skid entry is occupied, so one finished result may wait while items
  // keep entering.
  logic en, acc;
  logic skid_v_r;

  assign en       = !skid_v_r;
  assign in_ready = en;
  assign acc      = in_valid && en;

  logic [XW-1:0]  ext_x, ext_y, ext_z;
  logic [PTW-1:0] cur;
  logic [PW-1:0]  row_r, col_r, row_nxt, col_nxt, r0, c0;
  logic [DMW-1:0] r_inc, c_inc;

  // keep only the low COORD_BITS of each coordinate
  assign ext_x = XW'($unsigned(in_point_x));
  assign ext_y = XW'($unsigned(in_point_y));
  assign ext_z = XW'($unsigned(in_point_z));
  assign cur   = {ext_z[CB-1:0], ext_y[CB-1:0], ext_x[CB-1:0]};

  // start of frame zeroes the position before the point is placed
  assign r0    = in_start_of_frame ? '0 : row_r;
  assign c0    = in_start_of_frame ? '0 : col_r;
  assign r_inc = DMW'(r0) + DMW'(1);
  assign c_inc = DMW'(c0) + DMW'(1);

  always_comb begin
    if (c_inc >= w_used) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_used) ? '0 : r_inc[PW-1:0];
    end else begin
      col_nxt = c_inc[PW-1:0];
      row_nxt = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // ------------------------------------------------------- column store
  // One entry per column: the last four rows' points, oldest in slot 0.
  // Read at stage 0, rewrite at stage 1 with the new point shifted in.
  logic [EW-1:0] mem [MAX_WIDTH];
  logic [EW-1:0] rdata_r, wdata;
  logic [AW-1:0] ra;
  logic          s1_v_r, s1_wr_r;
  logic [AW-1:0] s1_addr_r;
  logic [PTW-1:0] s1_cur_r;
  logic [PW-1:0] s1_row_r, s1_col_r;
  logic          mem_we;

  assign ra     = AW'(c0);
  assign wdata  = {s1_cur_r, rdata_r[EW-1:PTW]};
  assign mem_we = en && s1_v_r && s1_wr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s1_addr_r] <= wdata;
    end
    if (en) begin
      // forward the entry being rewritten when a restart revisits it
      if (mem_we && (s1_addr_r == ra)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[ra];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cur_r  <= cur;
      s1_row_r  <= r0;
      s1_col_r  <= c0;
      s1_addr_r <= ra;
      s1_wr_r   <= (int'(c0) < MAX_WIDTH);
    end
  end

  // ------------------------------------------------------------ stage 1
  logic [PTW-1:0] colp [5];
  logic [PTW-1:0] win_r [5];
  logic [PTW-1:0] win_nxt [5];
  logic           r_ge4, vok, hok, has;
  logic signed [DW-1:0] va [3], vb [3], ha [3], hb [3];

  assign r_ge4 = s1_row_r >= PW'(4);
  assign has   = r_ge4 && (s1_col_r >= PW'(4)) &&
                 (DMW'(s1_row_r) < h_used) && (DMW'(s1_col_r) < w_used);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      colp[i] = rdata_r[i*PTW +: PTW];
    end
    colp[4] = s1_cur_r;
    // slide the center-row window only once a full column is available
    for (int i = 0; i < 5; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (r_ge4) begin
      for (int i = 0; i < 4; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[4] = colp[2];
    end
    vok = r_ge4;
    hok = 1'b1;
    for (int i = 0; i < 5; i++) begin
      if (colp[i] == '0) vok = 1'b0;
      if (win_nxt[i] == '0) hok = 1'b0;
    end
    for (int k = 0; k < 3; k++) begin
      va[k] = DW'($signed(colp[1][k*CB +: CB])) - DW'($signed(colp[0][k*CB +: CB]));
      vb[k] = DW'($signed(colp[4][k*CB +: CB])) - DW'($signed(colp[3][k*CB +: CB]));
      ha[k] = DW'($signed(win_nxt[1][k*CB +: CB])) - DW'($signed(win_nxt[0][k*CB +: CB]));
      hb[k] = DW'($signed(win_nxt[4][k*CB +: CB])) - DW'($signed(win_nxt[3][k*CB +: CB]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        win_r[i] <= '0;
      end
    end else if (en && s1_v_r) begin
      for (int i = 0; i < 5; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // ------------------------------------------------------------ stage 2
  logic signed [DW-1:0] va_r [3], vb_r [3], ha_r [3], hb_r [3];
  meta_t s2_meta_r;
  meta_t meta_r [LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        va_r[k] <= va[k];
        vb_r[k] <= vb[k];
        ha_r[k] <= ha[k];
        hb_r[k] <= hb[k];
      end
    end
  end

  // carry each item's position and window flags alongside the cosine tests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_meta_r.v <= 1'b0;
      for (int i = 0; i < LAT; i++) begin
        meta_r[i].v <= 1'b0;
      end
    end else if (en) begin
      s2_meta_r.v   <= s1_v_r;
      s2_meta_r.has <= has;
      s2_meta_r.vok <= vok;
      s2_meta_r.hok <= hok;
      s2_meta_r.row <= s1_row_r - PW'(2);
      s2_meta_r.col <= s1_col_r - PW'(2);
      meta_r[0]     <= s2_meta_r;
      for (int i = 1; i < LAT; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  // ------------------------------------------------------- cosine tests
  logic below_v, below_h;

  dgld_cos #(.CB(CB)) u_cos_v (
    .clk (clk), .en (en),
    .ax (va_r[0]), .ay (va_r[1]), .az (va_r[2]),
    .bx (vb_r[0]), .by (vb_r[1]), .bz (vb_r[2]),
    .thr (cos_thr_r), .below (below_v)
  );

  dgld_cos #(.CB(CB)) u_cos_h (
    .clk (clk), .en (en),
    .ax (ha_r[0]), .ay (ha_r[1]), .az (ha_r[2]),
    .bx (hb_r[0]), .by (hb_r[1]), .bz (hb_r[2]),
    .thr (cos_thr_r), .below (below_h)
  );

  // -------------------------------------------------------------- exit
  // The vertical verdict of each item is paired with the horizontal test
  // two items later, when its column has become the center column.
  meta_t     ex_meta;
  logic      ex, push, cand, leap;
  vverdict_t vnow, vp0_r, vp1_r;

  assign ex_meta  = meta_r[LAT-1];
  assign ex       = en && ex_meta.v;
  assign push     = ex && ex_meta.has;
  assign vnow.ok  = ex_meta.vok;
  assign vnow.low = ex_meta.vok && below_v;
  assign cand     = ex_meta.hok && vp1_r.ok;
  assign leap     = cand && vp1_r.low && below_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp0_r <= '0;
      vp1_r <= '0;
    end else if (ex) begin
      vp0_r <= vnow;
      vp1_r <= vp0_r;
    end
  end

  // --------------------------------------------------- output and skid
  logic          out_v_r;
  logic [PW-1:0] o_row_r, o_col_r, k_row_r, k_col_r;
  logic          o_cand_r, o_leap_r, k_cand_r, k_leap_r;
  logic          pop;

  assign pop = out_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      priority if (pop && skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else if (pop || !out_v_r) begin
        out_v_r  <= push;
      end else if (push) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (pop && skid_v_r) begin
      o_row_r  <= k_row_r;
      o_col_r  <= k_col_r;
      o_cand_r <= k_cand_r;
      o_leap_r <= k_leap_r;
    end else if (pop || !out_v_r) begin
      o_row_r  <= ex_meta.row;
      o_col_r  <= ex_meta.col;
      o_cand_r <= cand;
      o_leap_r <= leap;
    end else if (push) begin
      k_row_r  <= ex_meta.row;
      k_col_r  <= ex_meta.col;
      k_cand_r <= cand;
      k_leap_r <= leap;
    end
  end

  assign out_valid        = out_v_r;
  assign out_center_row   = o_row_r;
  assign out_center_col   = o_col_r;
  assign out_is_candidate = o_cand_r;
  assign out_is_leap      = o_leap_r;

  // ---------------------------------------------------------- checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held without a waiting output item");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ready))
    else $error("skid entry filled while output was free");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_start_of_frame |=> (col_r == PW'(1)) && (row_r == '0))
    else $error("position not restarted by start of frame");

  a_no_push_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !push)
    else $error("result pushed while pipeline stalled");

endmodule

// ===== hw/rtl/dgld_mul.sv =====
module dgld_mul #(
  parameter int WA    = 36,
  parameter int WB    = 36,
  parameter int STEPS = 4
) (
  input  logic            clk,
  input  logic            en,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic [WA+WB-1:0] p
);

  localparam int CW = (WB + STEPS - 1) / STEPS;
  localparam int BP = CW * STEPS;
  localparam int PW = WA + WB;
  localparam int QW = WA + CW;

  logic [WA-1:0] a_r   [STEPS-1];
  logic [BP-1:0] b_r   [STEPS-1];
  logic [PW-1:0] acc_r [STEPS];
  logic [QW-1:0] pp    [STEPS];
  logic [BP-1:0] b_pad;

  assign b_pad = BP'(b);

  // one partial product of a by one chunk of b per step
  always_comb begin
    pp[0] = QW'(a) * QW'(b_pad[CW-1:0]);
    for (int k = 1; k < STEPS; k++) begin
      pp[k] = QW'(a_r[k-1]) * QW'(b_r[k-1][k*CW +: CW]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]   <= a;
      b_r[0]   <= b_pad;
      acc_r[0] <= PW'(pp[0]);
      for (int k = 1; k < STEPS - 1; k++) begin
        a_r[k] <= a_r[k-1];
        b_r[k] <= b_r[k-1];
      end
      for (int k = 1; k < STEPS; k++) begin
        acc_r[k] <= acc_r[k-1] + (PW'(pp[k]) << (k * CW));
      end
    end
  end

  assign p = acc_r[STEPS-1];

endmodule

// ===== hw/rtl/dgld_cos.sv =====
module dgld_cos #(
  parameter int CB = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [CB:0]             ax,
  input  logic signed [CB:0]             ay,
  input  logic signed [CB:0]             az,
  input  logic signed [CB:0]             bx,
  input  logic signed [CB:0]             by,
  input  logic signed [CB:0]             bz,
  input  logic signed [dgld_pkg::THR_W-1:0] thr,
  output logic                           below
);

  localparam int NW  = 2 * CB + 2;
  localparam int TW  = dgld_pkg::T2_W;
  localparam int MW  = NW + TW;
  localparam int LW  = 2 * NW + TW;
  localparam int SW  = NW + 2;

  typedef struct packed {
    logic zero;
    logic tpos;
    logic dneg;
  } cos_flag_t;

  logic signed [NW-1:0] sa_r [3];
  logic signed [NW-1:0] sb_r [3];
  logic signed [NW-1:0] sd_r [3];
  logic signed [dgld_pkg::THR_W-1:0] thr1_r;

  logic signed [SW-1:0] na_s, nb_s, d_s, dabs_s;
  logic signed [31:0]   t2_full;
  logic [NW-1:0] na_r, nb_r, dabs_r;
  logic [TW-1:0] t2_r;
  cos_flag_t     fl2_r;
  cos_flag_t     fl_r [6];
  logic [NW-1:0] nb_d_r [2];

  logic [2*NW-1:0] d2;
  logic [MW-1:0]   m1;
  logic [MW+NW-1:0] m2;
  logic [LW-1:0]   lhs, rhs;
  logic            below_r;

  // squares and cross products of the component differences
  always_ff @(posedge clk) begin
    if (en) begin
      sa_r[0] <= NW'(ax) * NW'(ax);
      sa_r[1] <= NW'(ay) * NW'(ay);
      sa_r[2] <= NW'(az) * NW'(az);
      sb_r[0] <= NW'(bx) * NW'(bx);
      sb_r[1] <= NW'(by) * NW'(by);
      sb_r[2] <= NW'(bz) * NW'(bz);
      sd_r[0] <= NW'(ax) * NW'(bx);
      sd_r[1] <= NW'(ay) * NW'(by);
      sd_r[2] <= NW'(az) * NW'(bz);
      thr1_r  <= thr;
    end
  end

  always_comb begin
    na_s    = SW'(sa_r[0]) + SW'(sa_r[1]) + SW'(sa_r[2]);
    nb_s    = SW'(sb_r[0]) + SW'(sb_r[1]) + SW'(sb_r[2]);
    d_s     = SW'(sd_r[0]) + SW'(sd_r[1]) + SW'(sd_r[2]);
    dabs_s  = (d_s < 0) ? -d_s : d_s;
    t2_full = 32'(thr1_r) * 32'(thr1_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_r       <= na_s[NW-1:0];
      nb_r       <= nb_s[NW-1:0];
      dabs_r     <= dabs_s[NW-1:0];
      t2_r       <= t2_full[TW-1:0];
      fl2_r.zero <= (na_s == '0) || (nb_s == '0);
      fl2_r.tpos <= thr1_r > 0;
      fl2_r.dneg <= d_s < 0;
      nb_d_r[0]  <= nb_r;
      nb_d_r[1]  <= nb_d_r[0];
      fl_r[0]    <= fl2_r;
      for (int k = 1; k < 6; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  dgld_mul #(.WA(NW), .WB(NW), .STEPS(6)) u_mul_d2 (
    .clk (clk), .en (en), .a (dabs_r), .b (dabs_r), .p (d2)
  );

  dgld_mul #(.WA(NW), .WB(TW), .STEPS(2)) u_mul_m1 (
    .clk (clk), .en (en), .a (na_r), .b (t2_r), .p (m1)
  );

  dgld_mul #(.WA(MW), .WB(NW), .STEPS(4)) u_mul_m2 (
    .clk (clk), .en (en), .a (m1), .b (nb_d_r[1]), .p (m2)
  );

  assign lhs = LW'(d2) << dgld_pkg::SQ_SHIFT;
  assign rhs = LW'(m2);

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (fl_r[5].zero) begin
        below_r <= 1'b0;
      end else if (fl_r[5].tpos && fl_r[5].dneg) begin
        below_r <= 1'b1;
      end else if (!fl_r[5].tpos && !fl_r[5].dneg) begin
        below_r <= 1'b0;
      end else if (fl_r[5].tpos) begin
        below_r <= lhs < rhs;
      end else begin
        below_r <= lhs > rhs;
      end
    end
  end

  assign below = below_r;

endmodule
